>>> rtl/core/deq_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the double-ended symbol queue.
// No dependencies; used by the controller, the datapath and the top level.
package deq_pkg;

    // Default sizing of the queue
    localparam int DEFAULT_DEPTH       = 64;
    localparam int DEFAULT_SYMBOL_BITS = 16;

    // Operation code width and codes carried in the request tuser
    localparam int FUNC_BITS = 3;
    localparam logic [FUNC_BITS-1:0] FUNC_PUSH_BACK  = 3'd0;
    localparam logic [FUNC_BITS-1:0] FUNC_PUSH_FRONT = 3'd1;
    localparam logic [FUNC_BITS-1:0] FUNC_POP_BACK   = 3'd2;
    localparam logic [FUNC_BITS-1:0] FUNC_POP_FRONT  = 3'd3;
    localparam logic [FUNC_BITS-1:0] FUNC_CLEAR      = 3'd4;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic accept;   // latch a new request
        logic exec;     // apply the operation, issue the pop read or the write
        logic back;     // capture popped data, issue the back peek read
        logic commit;   // load the result register
    } deq_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic out_free; // result register can take a new result this cycle
    } deq_status_t;

endpackage

>>> rtl/core/deq_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module deq_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/core/deq_ctrl.sv
`timescale 1ns / 1ps
// Sequencing controller of the double-ended symbol queue.
// Depends on deq_pkg for the command and status structs.
module deq_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  deq_pkg::deq_status_t status,
    output deq_pkg::deq_cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_EXEC   = 4'b0010,
        ST_BACK   = 4'b0100,
        ST_RESULT = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    cmd.accept = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                cmd.exec   = 1'b1;
                state_next = ST_BACK;
            end
            ST_BACK: begin
                cmd.back   = 1'b1;
                state_next = ST_RESULT;
            end
            ST_RESULT: begin
                // hold the peek data until the result register frees up
                if (status.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);

endmodule

>>> rtl/core/deq_datapath.sv
`timescale 1ns / 1ps
// Datapath of the double-ended symbol queue: front and count registers,
// circular symbol store, result register. Depends on deq_pkg and deq_ram.
module deq_datapath #(
    parameter int DEPTH       = deq_pkg::DEFAULT_DEPTH,
    parameter int SYMBOL_BITS = deq_pkg::DEFAULT_SYMBOL_BITS,
    parameter int IDX_W       = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    parameter int CNT_W       = $clog2(DEPTH + 1)
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  deq_pkg::deq_cmd_t             cmd,
    output deq_pkg::deq_status_t          status,
    input  logic [deq_pkg::FUNC_BITS-1:0] req_func,
    input  logic [SYMBOL_BITS-1:0]        req_symbol,
    input  logic                          m_ready,
    output logic                          m_valid,
    output logic [SYMBOL_BITS-1:0]        res_popped_symbol,
    output logic                          res_popped_valid,
    output logic [SYMBOL_BITS-1:0]        res_back_symbol,
    output logic                          res_back_valid,
    output logic [CNT_W-1:0]              res_entry_count,
    output logic                          res_push_dropped
);

    localparam int SUM_W = CNT_W + 1;

    // Request and queue state
    logic [deq_pkg::FUNC_BITS-1:0] func_reg;
    logic [SYMBOL_BITS-1:0]        symbol_reg;
    logic [IDX_W-1:0]              front_reg;
    logic [CNT_W-1:0]              count_reg;
    logic                          pop_ok_reg;
    logic                          dropped_reg;
    logic [SYMBOL_BITS-1:0]        popped_reg;

    // Result register
    logic                   out_valid_reg;
    logic [SYMBOL_BITS-1:0] out_popped_reg;
    logic                   out_pop_ok_reg;
    logic [SYMBOL_BITS-1:0] out_back_reg;
    logic                   out_back_ok_reg;
    logic [CNT_W-1:0]       out_count_reg;
    logic                   out_dropped_reg;

    logic                   full;
    logic                   empty;
    logic [SUM_W-1:0]       tail_sum;
    logic [SUM_W-1:0]       back_sum;
    logic [SUM_W-1:0]       tail_wrap;
    logic [SUM_W-1:0]       back_wrap;
    logic [IDX_W-1:0]       tail_pos;
    logic [IDX_W-1:0]       back_pos;
    logic [IDX_W-1:0]       front_dec;
    logic [IDX_W-1:0]       front_inc;

    logic                   ram_wr_en;
    logic [IDX_W-1:0]       ram_wr_addr;
    logic                   ram_rd_en;
    logic [IDX_W-1:0]       ram_rd_addr;
    logic [SYMBOL_BITS-1:0] ram_rd_data;

    logic                   is_pop;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);

    // Circular positions: first free slot past the back, and the back slot
    assign tail_sum  = SUM_W'(front_reg) + SUM_W'(count_reg);
    assign back_sum  = SUM_W'(front_reg) + SUM_W'(count_reg - CNT_W'(1));
    assign tail_wrap = (tail_sum >= SUM_W'(DEPTH)) ? tail_sum - SUM_W'(DEPTH) : tail_sum;
    assign back_wrap = (back_sum >= SUM_W'(DEPTH)) ? back_sum - SUM_W'(DEPTH) : back_sum;
    assign tail_pos  = tail_wrap[IDX_W-1:0];
    assign back_pos  = back_wrap[IDX_W-1:0];
    assign front_dec = (front_reg == '0) ? IDX_W'(DEPTH - 1) : front_reg - IDX_W'(1);
    assign front_inc = (front_reg == IDX_W'(DEPTH - 1)) ? '0 : front_reg + IDX_W'(1);

    // Store port control
    always_comb begin
        ram_wr_en   = 1'b0;
        ram_wr_addr = tail_pos;
        ram_rd_en   = 1'b0;
        ram_rd_addr = back_pos;
        is_pop      = 1'b0;
        if (cmd.exec) begin
            case (func_reg)
                deq_pkg::FUNC_PUSH_BACK: begin
                    ram_wr_en   = !full;
                    ram_wr_addr = tail_pos;
                end
                deq_pkg::FUNC_PUSH_FRONT: begin
                    ram_wr_en   = !full;
                    ram_wr_addr = front_dec;
                end
                deq_pkg::FUNC_POP_BACK: begin
                    is_pop      = !empty;
                    ram_rd_en   = !empty;
                    ram_rd_addr = back_pos;
                end
                deq_pkg::FUNC_POP_FRONT: begin
                    is_pop      = !empty;
                    ram_rd_en   = !empty;
                    ram_rd_addr = front_reg;
                end
                default: begin
                end
            endcase
        end else if (cmd.back) begin
            // peek the back with the updated front and count
            ram_rd_en   = 1'b1;
            ram_rd_addr = back_pos;
        end
    end

    // Front and count update
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_reg <= '0;
            count_reg <= '0;
        end else if (cmd.exec) begin
            case (func_reg)
                deq_pkg::FUNC_PUSH_BACK: begin
                    if (!full) begin
                        count_reg <= count_reg + CNT_W'(1);
                    end
                end
                deq_pkg::FUNC_PUSH_FRONT: begin
                    if (!full) begin
                        front_reg <= front_dec;
                        count_reg <= count_reg + CNT_W'(1);
                    end
                end
                deq_pkg::FUNC_POP_BACK: begin
                    if (!empty) begin
                        count_reg <= count_reg - CNT_W'(1);
                    end
                end
                deq_pkg::FUNC_POP_FRONT: begin
                    if (!empty) begin
                        front_reg <= front_inc;
                        count_reg <= count_reg - CNT_W'(1);
                    end
                end
                deq_pkg::FUNC_CLEAR: begin
                    front_reg <= '0;
                    count_reg <= '0;
                end
                default: begin
                end
            endcase
        end
    end

    // Request latch and per-request flags
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            func_reg    <= req_func;
            symbol_reg  <= req_symbol;
            pop_ok_reg  <= 1'b0;
            dropped_reg <= 1'b0;
        end
        if (cmd.exec) begin
            pop_ok_reg  <= is_pop;
            dropped_reg <= full && ((func_reg == deq_pkg::FUNC_PUSH_BACK) ||
                                    (func_reg == deq_pkg::FUNC_PUSH_FRONT));
        end
        if (cmd.back) begin
            popped_reg <= pop_ok_reg ? ram_rd_data : '0;
        end
    end

    deq_ram #(
        .WIDTH (SYMBOL_BITS),
        .DEPTH (DEPTH),
        .ADDR_W(IDX_W)
    ) u_store (
        .aclk   (aclk),
        .wr_en  (ram_wr_en),
        .wr_addr(ram_wr_addr),
        .wr_data(symbol_reg),
        .rd_en  (ram_rd_en),
        .rd_addr(ram_rd_addr),
        .rd_data(ram_rd_data)
    );

    // Result register valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.commit) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result register payload
    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            out_popped_reg  <= popped_reg;
            out_pop_ok_reg  <= pop_ok_reg;
            out_back_reg    <= empty ? '0 : ram_rd_data;
            out_back_ok_reg <= !empty;
            out_count_reg   <= count_reg;
            out_dropped_reg <= dropped_reg;
        end
    end

    assign status.out_free   = !out_valid_reg || m_ready;
    assign m_valid           = out_valid_reg;
    assign res_popped_symbol = out_popped_reg;
    assign res_popped_valid  = out_pop_ok_reg;
    assign res_back_symbol   = out_back_reg;
    assign res_back_valid    = out_back_ok_reg;
    assign res_entry_count   = out_count_reg;
    assign res_push_dropped  = out_dropped_reg;

endmodule

>>> rtl/core/double_ended_symbol_queue.sv
`timescale 1ns / 1ps
// Double-ended symbol queue: the top level, joining controller and datapath.
// Depends on deq_pkg, deq_ctrl, deq_datapath and deq_ram.

// A bounded deque of up to DEPTH symbols in a circular store. Each request
// carries an operation in s_axis_tuser (push back, push front, pop back, pop
// front, clear; other codes do nothing) and a symbol in s_axis_tdata. Every
// request yields exactly one result: the popped symbol and its valid flag,
// the symbol now at the back and its valid flag, the count after the
// operation, and a flag for a push refused because the queue was full.
// A request passes in turn through the steps latch, execute, back peek and
// result load, set by the store's single read port: a pop reads the removed
// symbol and then the new back symbol in turn. The result sits in an output
// register, so the next request is taken while the previous result waits.
// The store needs no clearing pass after reset; clear resets the pointers only.
module double_ended_symbol_queue #(
    parameter int DEPTH       = deq_pkg::DEFAULT_DEPTH,
    parameter int SYMBOL_BITS = deq_pkg::DEFAULT_SYMBOL_BITS,
    parameter int CNT_W       = $clog2(DEPTH + 1),
    parameter int IN_W        = ((SYMBOL_BITS + 7) / 8) * 8,
    parameter int OUT_W       = ((2 * SYMBOL_BITS + CNT_W + 3 + 7) / 8) * 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // request channel
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [IN_W-1:0]               s_axis_tdata,  // symbol
    input  logic [deq_pkg::FUNC_BITS-1:0] s_axis_tuser,  // func
    // result channel
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // popped_symbol, popped_valid, back_symbol, back_valid, entry_count,
    // push_dropped, zero fill
    output logic [OUT_W-1:0]              m_axis_tdata
);

    localparam int IDX_W       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int POP_LSB     = 0;
    localparam int POP_OK_BIT  = SYMBOL_BITS;
    localparam int BACK_LSB    = SYMBOL_BITS + 1;
    localparam int BACK_OK_BIT = 2 * SYMBOL_BITS + 1;
    localparam int CNT_LSB     = 2 * SYMBOL_BITS + 2;
    localparam int DROP_BIT    = 2 * SYMBOL_BITS + 2 + CNT_W;
    localparam int PAD_W       = OUT_W - (DROP_BIT + 1);

    deq_pkg::deq_cmd_t    cmd;
    deq_pkg::deq_status_t status;

    logic [SYMBOL_BITS-1:0] res_popped_symbol;
    logic                   res_popped_valid;
    logic [SYMBOL_BITS-1:0] res_back_symbol;
    logic                   res_back_valid;
    logic [CNT_W-1:0]       res_entry_count;
    logic                   res_push_dropped;

    deq_ctrl u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .status       (status),
        .cmd          (cmd)
    );

    deq_datapath #(
        .DEPTH      (DEPTH),
        .SYMBOL_BITS(SYMBOL_BITS),
        .IDX_W      (IDX_W),
        .CNT_W      (CNT_W)
    ) u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .status           (status),
        .req_func         (s_axis_tuser),
        .req_symbol       (s_axis_tdata[SYMBOL_BITS-1:0]),
        .m_ready          (m_axis_tready),
        .m_valid          (m_axis_tvalid),
        .res_popped_symbol(res_popped_symbol),
        .res_popped_valid (res_popped_valid),
        .res_back_symbol  (res_back_symbol),
        .res_back_valid   (res_back_valid),
        .res_entry_count  (res_entry_count),
        .res_push_dropped (res_push_dropped)
    );

    // Pack the result fields, lowest field first
    assign m_axis_tdata = {{PAD_W{1'b0}}, res_push_dropped, res_entry_count,
                           res_back_valid, res_back_symbol,
                           res_popped_valid, res_popped_symbol};

`ifndef ASSERT_OFF
    // count reported never exceeds the capacity
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (m_axis_tdata[CNT_LSB +: CNT_W] <= CNT_W'(DEPTH)))
        else $error("entry_count above capacity");

    // back_valid tracks a nonzero count
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (m_axis_tdata[BACK_OK_BIT] ==
                           (m_axis_tdata[CNT_LSB +: CNT_W] != '0)))
        else $error("back_valid disagrees with entry_count");

    // a request is either a pop or a push, never both outcomes
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> !(m_axis_tdata[POP_OK_BIT] && m_axis_tdata[DROP_BIT]))
        else $error("pop and dropped push flagged together");

    // a popped symbol is zero unless flagged valid
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tdata[POP_OK_BIT]) |->
            (m_axis_tdata[POP_LSB +: SYMBOL_BITS] == '0))
        else $error("popped_symbol nonzero without a pop");

    // the block is busy in the cycle after taking a request
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("request taken while a request is in flight");
`endif

endmodule
